### rtl/core/fta_pkg.sv
// ----------------------------------------------------------------------------
// Flow table package
// Shared types, constants and the TCP phase function of the flow table.
// ----------------------------------------------------------------------------
`default_nettype none

package fta_pkg;

	// Table shape; BUCKETS and WAYS are powers of two (bucket = low hash bits)
	localparam int BUCKETS = 1024;
	localparam int WAYS    = 4;
	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int WAY_W   = $clog2(WAYS);

	localparam int SLOT_W = 12;
	localparam int CNT_W  = 13;
	localparam int TMO_W  = 31;

	localparam logic [TMO_W-1:0] TMO_RESET = 31'd300;

	localparam logic [31:0] FNV_BASIS  = 32'h811C9DC5;
	localparam logic [31:0] FNV_PRIME  = 32'h01000193;
	localparam logic [2:0]  HASH_STEPS = 3'd5;

	localparam logic REQ_PKT   = 1'b0;
	localparam logic REQ_SWEEP = 1'b1;

	typedef logic [1:0]       phase_t;
	typedef logic [WAY_W-1:0] way_t;
	typedef logic [BKT_W-1:0] bkt_t;

	localparam phase_t PH_NONE   = 2'd0;
	localparam phase_t PH_SYN    = 2'd1;
	localparam phase_t PH_EST    = 2'd2;
	localparam phase_t PH_CLOSED = 2'd3;

	// One item on its way from the front to the back
	typedef struct packed {
		logic        req_type;
		logic        has_tcp;
		logic [7:0]  tcp_flags;
		logic [31:0] now_time;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port_num;
		logic [15:0] dst_port_num;
		logic [7:0]  proto_num;
		logic [15:0] pkt_length;
		bkt_t        bucket;
	} item_t;

	// One table entry
	typedef struct packed {
		logic        valid;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] port_pair;
		logic [7:0]  proto;
		logic [31:0] pkts;
		logic [63:0] bytes;
		logic [31:0] seen_time;
		phase_t      phase;
	} entry_t;

	typedef entry_t [WAYS-1:0] row_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              found_existing;
		logic              bucket_full;
		logic [31:0]       packet_count;
		logic [63:0]       byte_count;
		phase_t            flow_state;
		logic [CNT_W-1:0]  live_count;
		logic [CNT_W-1:0]  removed_count;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PKT_RD,
		ST_PKT_CMP,
		ST_PKT_WR,
		ST_SWP_RD,
		ST_SWP_WR
	} st_t;

	// SYN+ACK wins over SYN alone, which wins over FIN or RST
	function automatic phase_t next_phase(phase_t cur, logic [7:0] flags);
		phase_t res;
		if (flags[1] && flags[4]) res = PH_EST;
		else if (flags[1]) res = PH_SYN;
		else if (flags[0] || flags[2]) res = PH_CLOSED;
		else res = cur;
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/core/fta_front.sv
// ----------------------------------------------------------------------------
// Flow table front
// Accepts items and hashes the five-tuple, one FNV-1a word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fta_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clearing,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire fta_pkg::item_t in_item,
	output logic               push_valid,
	input  wire logic          push_ready,
	output fta_pkg::item_t     push_item
);

	fta_pkg::item_t item_q;
	logic           busy_q;
	logic [2:0]     step_q;
	logic [31:0]    h_q;
	logic [31:0]    word;
	logic [31:0]    mix;
	logic [31:0]    h_nx;

	always_comb begin
		case (step_q)
			3'd0:    word = item_q.src_addr;
			3'd1:    word = item_q.dst_addr;
			3'd2:    word = {16'b0, item_q.src_port_num};
			3'd3:    word = {16'b0, item_q.dst_port_num};
			default: word = {24'b0, item_q.proto_num};
		endcase
		mix  = h_q ^ word;
		h_nx = mix * fta_pkg::FNV_PRIME;
	end

	assign in_ready   = !busy_q && !clearing;
	assign push_valid = busy_q && (step_q == fta_pkg::HASH_STEPS);

	always_comb begin
		push_item        = item_q;
		push_item.bucket = h_q[fta_pkg::BKT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			h_q    <= fta_pkg::FNV_BASIS;
			item_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				item_q <= in_item;
				h_q    <= fta_pkg::FNV_BASIS;
				// sweeps skip the hash
				step_q <= (in_item.req_type == fta_pkg::REQ_SWEEP) ? fta_pkg::HASH_STEPS : 3'd0;
			end else if (busy_q && step_q != fta_pkg::HASH_STEPS) begin
				h_q    <= h_nx;
				step_q <= step_q + 3'd1;
			end else if (push_valid && push_ready) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/fta_queue.sv
// ----------------------------------------------------------------------------
// Flow table queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fta_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire fta_pkg::item_t push_item,
	output logic                pop_valid,
	input  wire logic           pop,
	output fta_pkg::item_t      pop_item
);

	fta_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)      count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

### rtl/core/fta_back.sv
// ----------------------------------------------------------------------------
// Flow table back
// Holds the bucket memory; runs lookups, inserts, sweeps and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fta_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [fta_pkg::TMO_W-1:0]    cfg_wdata,
	input  wire logic                         q_valid,
	output logic                              q_pop,
	input  wire fta_pkg::item_t               q_item,
	output logic                              clearing,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output fta_pkg::result_t                  res
);

	localparam fta_pkg::bkt_t LAST_ROW = fta_pkg::BKT_W'(fta_pkg::BUCKETS - 1);

	fta_pkg::row_t mem [fta_pkg::BUCKETS];

	fta_pkg::st_t     state_q, state_nx;
	fta_pkg::item_t   cmd_s1;
	fta_pkg::row_t    row_q;
	fta_pkg::bkt_t    row_addr_q;
	fta_pkg::way_t    way_q;
	logic             hit_q;
	logic             full_q;
	logic [fta_pkg::CNT_W-1:0] live_q;
	logic [fta_pkg::CNT_W-1:0] removed_q;
	logic [fta_pkg::TMO_W-1:0] timeout_q;
	logic             out_valid_q;
	fta_pkg::result_t out_q;
	fta_pkg::result_t res_nx;

	logic             mem_we, mem_re;
	fta_pkg::row_t    mem_wdata;

	logic             hit, have_free;
	fta_pkg::way_t    hit_way, free_way;
	fta_pkg::entry_t  ent;
	fta_pkg::row_t    pkt_row;
	fta_pkg::row_t    swp_row;
	logic [fta_pkg::WAYS-1:0] expire;
	logic [fta_pkg::CNT_W-1:0] expired;
	logic [32:0]      idle;

	// Way match and first free way
	always_comb begin
		hit       = 1'b0;
		have_free = 1'b0;
		hit_way   = '0;
		free_way  = '0;
		for (int w = 0; w < fta_pkg::WAYS; w++) begin
			if (row_q[w].valid) begin
				if (!hit && row_q[w].src_addr == cmd_s1.src_addr
						&& row_q[w].dst_addr == cmd_s1.dst_addr
						&& row_q[w].port_pair == {cmd_s1.src_port_num, cmd_s1.dst_port_num}
						&& row_q[w].proto == cmd_s1.proto_num) begin
					hit     = 1'b1;
					hit_way = fta_pkg::way_t'(w);
				end
			end else if (!have_free) begin
				have_free = 1'b1;
				free_way  = fta_pkg::way_t'(w);
			end
		end
	end

	// Update or fill the chosen way
	always_comb begin
		ent = row_q[way_q];
		if (hit_q) begin
			ent.pkts      = ent.pkts + 32'd1;
			ent.bytes     = ent.bytes + {48'b0, cmd_s1.pkt_length};
			ent.seen_time = cmd_s1.now_time;
		end else begin
			ent.valid     = 1'b1;
			ent.src_addr  = cmd_s1.src_addr;
			ent.dst_addr  = cmd_s1.dst_addr;
			ent.port_pair = {cmd_s1.src_port_num, cmd_s1.dst_port_num};
			ent.proto     = cmd_s1.proto_num;
			ent.pkts      = 32'd1;
			ent.bytes     = {48'b0, cmd_s1.pkt_length};
			ent.seen_time = cmd_s1.now_time;
			ent.phase     = fta_pkg::PH_NONE;
		end
		if (cmd_s1.has_tcp) ent.phase = fta_pkg::next_phase(ent.phase, cmd_s1.tcp_flags);
		pkt_row        = row_q;
		pkt_row[way_q] = ent;
	end

	// Age out idle ways of one row; idleness is a signed difference
	always_comb begin
		swp_row = row_q;
		idle    = '0;
		for (int w = 0; w < fta_pkg::WAYS; w++) begin
			idle      = {1'b0, cmd_s1.now_time} - {1'b0, row_q[w].seen_time};
			expire[w] = row_q[w].valid && ($signed(idle) > $signed({2'b0, timeout_q}));
			if (expire[w]) swp_row[w].valid = 1'b0;
		end
		expired = fta_pkg::CNT_W'($countones(expire));
	end

	// Result of the item that finishes this cycle
	always_comb begin
		res_nx = '0;
		if (state_q == fta_pkg::ST_SWP_WR) begin
			res_nx.live_count    = live_q - expired;
			res_nx.removed_count = removed_q + expired;
		end else if (full_q) begin
			res_nx.bucket_full = 1'b1;
			res_nx.live_count  = live_q;
		end else begin
			res_nx.slot           = fta_pkg::SLOT_W'({row_addr_q, way_q});
			res_nx.found_existing = hit_q;
			res_nx.packet_count   = ent.pkts;
			res_nx.byte_count     = ent.bytes;
			res_nx.flow_state     = ent.phase;
			res_nx.live_count     = hit_q ? live_q : live_q + 1'b1;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			fta_pkg::ST_CLEAR:   if (row_addr_q == LAST_ROW) state_nx = fta_pkg::ST_IDLE;
			fta_pkg::ST_IDLE: begin
				if (q_valid && !out_valid_q)
					state_nx = (q_item.req_type == fta_pkg::REQ_SWEEP) ?
						fta_pkg::ST_SWP_RD : fta_pkg::ST_PKT_RD;
			end
			fta_pkg::ST_PKT_RD:  state_nx = fta_pkg::ST_PKT_CMP;
			fta_pkg::ST_PKT_CMP: state_nx = fta_pkg::ST_PKT_WR;
			fta_pkg::ST_PKT_WR:  state_nx = fta_pkg::ST_IDLE;
			fta_pkg::ST_SWP_RD:  state_nx = fta_pkg::ST_SWP_WR;
			fta_pkg::ST_SWP_WR:  state_nx = (row_addr_q == LAST_ROW) ?
				fta_pkg::ST_IDLE : fta_pkg::ST_SWP_RD;
			default:             state_nx = fta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = '0;
		q_pop     = 1'b0;
		unique case (state_q)
			fta_pkg::ST_CLEAR:  mem_we = 1'b1;
			fta_pkg::ST_IDLE:   q_pop  = q_valid && !out_valid_q;
			fta_pkg::ST_PKT_RD: mem_re = 1'b1;
			fta_pkg::ST_SWP_RD: mem_re = 1'b1;
			fta_pkg::ST_PKT_WR: begin
				mem_we    = !full_q;
				mem_wdata = pkt_row;
			end
			fta_pkg::ST_SWP_WR: begin
				mem_we    = 1'b1;
				mem_wdata = swp_row;
			end
			default: ;
		endcase
	end

	assign clearing  = (state_q == fta_pkg::ST_CLEAR);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[row_addr_q] <= mem_wdata;
		if (mem_re) row_q <= mem[row_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fta_pkg::ST_CLEAR;
			row_addr_q  <= '0;
			live_q      <= '0;
			removed_q   <= '0;
			timeout_q   <= fta_pkg::TMO_RESET;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			cmd_s1      <= '0;
			way_q       <= '0;
			hit_q       <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) timeout_q <= cfg_wdata;
			if (out_valid_q && res_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				fta_pkg::ST_CLEAR: row_addr_q <= row_addr_q + 1'b1;
				fta_pkg::ST_IDLE: begin
					if (q_pop) begin
						cmd_s1     <= q_item;
						removed_q  <= '0;
						row_addr_q <= (q_item.req_type == fta_pkg::REQ_SWEEP) ?
							'0 : q_item.bucket;
					end
				end
				fta_pkg::ST_PKT_CMP: begin
					hit_q  <= hit;
					full_q <= !hit && !have_free;
					way_q  <= hit ? hit_way : free_way;
				end
				fta_pkg::ST_PKT_WR: begin
					out_valid_q <= 1'b1;
					out_q       <= res_nx;
					if (!full_q && !hit_q) live_q <= live_q + 1'b1;
				end
				fta_pkg::ST_SWP_WR: begin
					live_q     <= live_q - expired;
					removed_q  <= removed_q + expired;
					row_addr_q <= row_addr_q + 1'b1;
					if (row_addr_q == LAST_ROW) begin
						out_valid_q <= 1'b1;
						out_q       <= res_nx;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/flow_table_with_aging.sv
// ----------------------------------------------------------------------------
// Five-tuple flow table with idle aging
// Top level: stream ports, field packing, front, queue and back.
// ----------------------------------------------------------------------------
// Packet beats look up their five-tuple (FNV-1a hash, low bits pick one of
// 1024 buckets of four ways), bump the counters of a matching flow or fill
// the lowest free way, and report a dropped packet when the bucket is full.
// A sweep beat walks the whole table and removes entries idle longer than
// idle_timeout. Every input beat yields exactly one result beat. The front
// takes a packet, hashes it one word per step and hands it to the queue
// before it accepts the next one; this sets the packet rate. The back then
// pops the item, reads the bucket, compares the ways and writes the row back
// with the result through the single-port bucket memory, and pops nothing
// more while the result beat drains. A sweep reads and writes back each
// bucket in turn. After reset the back clears the bucket memory, during
// which s_tready stays low; cfg writes are taken at any time but must only
// be issued while the block is idle.
`default_nettype none

module flow_table_with_aging (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [30:0]  cfg_wdata,   // idle_timeout
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// now_time, src_addr, dst_addr, src_port_num, dst_port_num, proto_num,
	// pkt_length, tcp_flags
	input  wire logic [159:0] s_tdata,
	input  wire logic [1:0]   s_tuser,     // req_type, has_tcp
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// slot, packet_count, byte_count, flow_state, live_count, removed_count
	output logic [135:0]      m_tdata,
	output logic [1:0]        m_tuser      // found_existing, bucket_full
);

	fta_pkg::item_t   in_item;
	fta_pkg::item_t   push_item;
	fta_pkg::item_t   pop_item;
	fta_pkg::result_t res;
	logic             push_valid, push_ready;
	logic             pop_valid, pop;
	logic             clearing;

	// Unpack the input beat; the bucket is filled in by the hash
	always_comb begin
		in_item.req_type     = s_tuser[0];
		in_item.has_tcp      = s_tuser[1];
		in_item.now_time     = s_tdata[31:0];
		in_item.src_addr     = s_tdata[63:32];
		in_item.dst_addr     = s_tdata[95:64];
		in_item.src_port_num = s_tdata[111:96];
		in_item.dst_port_num = s_tdata[127:112];
		in_item.proto_num    = s_tdata[135:128];
		in_item.pkt_length   = s_tdata[151:136];
		in_item.tcp_flags    = s_tdata[159:152];
		in_item.bucket       = '0;
	end

	fta_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Decouple hashing from table work
	fta_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	fta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (pop_valid),
		.q_pop     (pop),
		.q_item    (pop_item),
		.clearing  (clearing),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result beat
	assign m_tdata = {res.removed_count, res.live_count, res.flow_state,
		res.byte_count, res.packet_count, res.slot};
	assign m_tuser = {res.bucket_full, res.found_existing};

endmodule

`default_nettype wire

### tb/flow_table_with_aging_test.sv
// ----------------------------------------------------------------------------
// Flow table with aging: stream-level test
// Drives packet and sweep beats into the flow table, predicts every result
// beat from an independent table model and checks the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_table_with_aging_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES    = fta_pkg::BUCKETS * fta_pkg::WAYS;
	localparam int IDLE_LIMIT = 20000;   // longer than a sweep, the clearing and the hold-off

	// One input beat in field form
	typedef struct {
		logic        req_type;
		logic        has_tcp;
		logic [7:0]  tcp_flags;
		logic [31:0] now_time;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port_num;
		logic [15:0] dst_port_num;
		logic [7:0]  proto_num;
		logic [15:0] pkt_length;
	} flow_req_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [30:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic [1:0]   m_tuser;

	flow_table_with_aging u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Table model: mirror of the flow table contents
	// ------------------------------------------------------------------
	logic             tbl_valid [ENTRIES];
	logic [31:0]      tbl_src   [ENTRIES];
	logic [31:0]      tbl_dst   [ENTRIES];
	logic [31:0]      tbl_ports [ENTRIES];
	logic [7:0]       tbl_proto [ENTRIES];
	logic [31:0]      tbl_pkts  [ENTRIES];
	logic [63:0]      tbl_bytes [ENTRIES];
	logic [31:0]      tbl_last  [ENTRIES];
	fta_pkg::phase_t  tbl_phase [ENTRIES];
	int unsigned live_total = 0;
	logic [30:0] idle_tmo = fta_pkg::TMO_RESET;

	flow_req_t          pending_beats [$];
	fta_pkg::result_t   expected_results [$];
	flow_req_t   cur_beat;
	flow_req_t   flow_pool [$];
	int          err_cnt = 0;
	bit          quiet = 1'b0;       // no idling on either side
	bit          hold_req = 1'b0;    // ask the receiver for a long hold-off
	int          hold_cnt = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          idle_cycles = 0;
	logic [31:0] clock_now = 32'd1000;

	function automatic logic [fta_pkg::BKT_W-1:0] hash_bucket(flow_req_t r);
		logic [31:0] h;
		h = fta_pkg::FNV_BASIS;
		h = (h ^ r.src_addr) * fta_pkg::FNV_PRIME;
		h = (h ^ r.dst_addr) * fta_pkg::FNV_PRIME;
		h = (h ^ {16'd0, r.src_port_num}) * fta_pkg::FNV_PRIME;
		h = (h ^ {16'd0, r.dst_port_num}) * fta_pkg::FNV_PRIME;
		h = (h ^ {24'd0, r.proto_num}) * fta_pkg::FNV_PRIME;
		return h[fta_pkg::BKT_W-1:0];
	endfunction

	// Advance the table model by one beat and return its result
	function automatic fta_pkg::result_t table_update(flow_req_t r);
		fta_pkg::result_t res;
		int      base, e, free_e;
		bit      hit, have_free;
		logic [31:0] ports;
		fta_pkg::phase_t nxt;
		res = '0;
		if (r.req_type == fta_pkg::REQ_SWEEP) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (tbl_valid[i] &&
				    (longint'(r.now_time) - longint'(tbl_last[i]) > longint'(idle_tmo))) begin
					tbl_valid[i] = 1'b0;
					live_total--;
					res.removed_count++;
				end
			end
		end else begin
			base = int'(hash_bucket(r)) * fta_pkg::WAYS;
			ports = {r.src_port_num, r.dst_port_num};
			hit = 0;
			have_free = 0;
			e = 0;
			free_e = 0;
			for (int w = 0; w < fta_pkg::WAYS; w++) begin
				if (tbl_valid[base+w]) begin
					if (!hit && tbl_src[base+w] == r.src_addr && tbl_dst[base+w] == r.dst_addr &&
					    tbl_ports[base+w] == ports && tbl_proto[base+w] == r.proto_num) begin
						hit = 1;
						e = base + w;
					end
				end else if (!have_free) begin
					have_free = 1;
					free_e = base + w;
				end
			end
			if (hit) begin
				tbl_pkts[e] += 32'd1;
				tbl_bytes[e] += 64'(r.pkt_length);
				tbl_last[e] = r.now_time;
				res.found_existing = 1'b1;
			end else if (have_free) begin
				e = free_e;
				tbl_valid[e] = 1'b1;
				tbl_src[e] = r.src_addr;
				tbl_dst[e] = r.dst_addr;
				tbl_ports[e] = ports;
				tbl_proto[e] = r.proto_num;
				tbl_pkts[e] = 32'd1;
				tbl_bytes[e] = 64'(r.pkt_length);
				tbl_last[e] = r.now_time;
				tbl_phase[e] = fta_pkg::PH_NONE;
				live_total++;
			end else begin
				res.bucket_full = 1'b1;
			end
			if (!res.bucket_full) begin
				// SYN+ACK first, then SYN, then FIN or RST
				if (r.has_tcp) begin
					nxt = tbl_phase[e];
					if (r.tcp_flags[1] && r.tcp_flags[4]) nxt = fta_pkg::PH_EST;
					else if (r.tcp_flags[1]) nxt = fta_pkg::PH_SYN;
					else if (r.tcp_flags[0] || r.tcp_flags[2]) nxt = fta_pkg::PH_CLOSED;
					tbl_phase[e] = nxt;
				end
				res.slot = fta_pkg::SLOT_W'(e);
				res.packet_count = tbl_pkts[e];
				res.byte_count = tbl_bytes[e];
				res.flow_state = tbl_phase[e];
			end
		end
		res.live_count = fta_pkg::CNT_W'(live_total);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Sender: feed beats from the pending queue, with random gaps
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (s_tvalid) begin
				expected_results.push_back(table_update(cur_beat));
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				cur_beat = pending_beats.pop_front();
				s_tdata <= {cur_beat.tcp_flags, cur_beat.pkt_length, cur_beat.proto_num,
				            cur_beat.dst_port_num, cur_beat.src_port_num, cur_beat.dst_addr,
				            cur_beat.src_addr, cur_beat.now_time};
				s_tuser <= {cur_beat.has_tcp, cur_beat.req_type};
				s_tvalid <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 7);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls plus one long hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_req <= 1'b0;
				hold_cnt <= 400;
				m_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				recv_gap <= $urandom_range(0, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result beat with the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		fta_pkg::result_t exp_r;
		fta_pkg::result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.slot           = m_tdata[11:0];
			got.packet_count   = m_tdata[43:12];
			got.byte_count     = m_tdata[107:44];
			got.flow_state     = m_tdata[109:108];
			got.live_count     = m_tdata[122:110];
			got.removed_count  = m_tdata[135:123];
			got.found_existing = m_tuser[0];
			got.bucket_full    = m_tuser[1];
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: slot %0d", got.slot);
				err_cnt++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got.slot !== exp_r.slot) begin
					$error("slot: expected %0d, got %0d", exp_r.slot, got.slot);
					err_cnt++;
				end
				if (got.found_existing !== exp_r.found_existing) begin
					$error("found_existing: expected %0d, got %0d",
					       exp_r.found_existing, got.found_existing);
					err_cnt++;
				end
				if (got.bucket_full !== exp_r.bucket_full) begin
					$error("bucket_full: expected %0d, got %0d", exp_r.bucket_full, got.bucket_full);
					err_cnt++;
				end
				if (got.packet_count !== exp_r.packet_count) begin
					$error("packet_count: expected %0d, got %0d",
					       exp_r.packet_count, got.packet_count);
					err_cnt++;
				end
				if (got.byte_count !== exp_r.byte_count) begin
					$error("byte_count: expected %0d, got %0d", exp_r.byte_count, got.byte_count);
					err_cnt++;
				end
				if (got.flow_state !== exp_r.flow_state) begin
					$error("flow_state: expected %0d, got %0d", exp_r.flow_state, got.flow_state);
					err_cnt++;
				end
				if (got.live_count !== exp_r.live_count) begin
					$error("live_count: expected %0d, got %0d", exp_r.live_count, got.live_count);
					err_cnt++;
				end
				if (got.removed_count !== exp_r.removed_count) begin
					$error("removed_count: expected %0d, got %0d",
					       exp_r.removed_count, got.removed_count);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic flow_req_t rand_flow();
		flow_req_t r;
		r.req_type     = fta_pkg::REQ_PKT;
		r.has_tcp      = 1'($urandom_range(0, 1));
		r.tcp_flags    = 8'($urandom_range(0, 255));
		r.now_time     = 32'd0;
		r.src_addr     = $urandom;
		r.dst_addr     = $urandom;
		r.src_port_num = 16'($urandom_range(0, 65535));
		r.dst_port_num = 16'($urandom_range(0, 65535));
		r.proto_num    = 8'($urandom_range(0, 255));
		r.pkt_length   = 16'($urandom_range(0, 65535));
		return r;
	endfunction

	// Search for a random five-tuple that lands in a given bucket
	function automatic flow_req_t flow_in_bucket(logic [fta_pkg::BKT_W-1:0] bkt);
		flow_req_t r;
		r = rand_flow();
		while (hash_bucket(r) != bkt) r.src_addr = $urandom;
		return r;
	endfunction

	// Refill the pool: a few loose flows plus crowded buckets that overflow
	task automatic build_pool();
		logic [fta_pkg::BKT_W-1:0] bkt;
		flow_pool.delete();
		for (int i = 0; i < 12; i++) flow_pool.push_back(rand_flow());
		for (int b = 0; b < 3; b++) begin
			bkt = fta_pkg::BKT_W'($urandom_range(0, fta_pkg::BUCKETS - 1));
			for (int i = 0; i < fta_pkg::WAYS + 2; i++) flow_pool.push_back(flow_in_bucket(bkt));
		end
	endtask

	// Queue one random beat; mostly known flows, rarely sweeps
	task automatic push_random_beat();
		flow_req_t r;
		int        roll;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 49) == 0) clock_now -= $urandom_range(0, 200);
		else clock_now += $urandom_range(0, 40);
		if (roll < 3) begin
			r = rand_flow();
			r.req_type = fta_pkg::REQ_SWEEP;
			if ($urandom_range(0, 3) == 0) r.now_time = $urandom;
			else r.now_time = clock_now;
		end else begin
			if (roll < 88) r = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
			else r = rand_flow();
			r.has_tcp    = 1'($urandom_range(0, 1));
			r.tcp_flags  = 8'($urandom_range(0, 255));
			r.pkt_length = 16'($urandom_range(0, 65535));
			r.now_time   = clock_now;
		end
		pending_beats.push_back(r);
	endtask

	// Hold until the sender is drained and every result has come back
	task automatic wait_drained();
		@(posedge clk);
		while (pending_beats.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_timeout(logic [30:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		idle_tmo = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_pkt(flow_req_t r, logic [31:0] t, logic tcp, logic [7:0] fl);
		r.req_type = fta_pkg::REQ_PKT;
		r.now_time = t;
		r.has_tcp = tcp;
		r.tcp_flags = fl;
		pending_beats.push_back(r);
	endtask

	task automatic push_sweep(logic [31:0] t);
		flow_req_t r;
		r = rand_flow();
		r.req_type = fta_pkg::REQ_SWEEP;
		r.now_time = t;
		pending_beats.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		flow_req_t f0, f1, crowd;
		logic [fta_pkg::BKT_W-1:0] bkt;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_phase[i] = fta_pkg::PH_NONE;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every TCP phase rule, a full bucket, sweeps
		f0 = '{default: '0};
		push_pkt(f0, 32'd0, 1'b0, 8'hFF);
		f1 = '{default: '1};
		push_pkt(f1, 32'hFFFF_FFFF, 1'b1, 8'h00);      // flags leave phase as is
		f1.pkt_length = 16'd1;
		push_pkt(f1, 32'hFFFF_FFFF, 1'b1, 8'h02);      // SYN alone
		push_pkt(f1, 32'hFFFF_FFFF, 1'b1, 8'h12);      // SYN with ACK
		push_pkt(f1, 32'hFFFF_FFFF, 1'b1, 8'h01);      // FIN
		push_pkt(f1, 32'hFFFF_FFFF, 1'b1, 8'h13);      // SYN+ACK beats FIN
		push_pkt(f1, 32'hFFFF_FFFF, 1'b1, 8'h04);      // RST
		push_pkt(f1, 32'hFFFF_FFFF, 1'b1, 8'h10);      // ACK alone: unchanged
		push_pkt(f1, 32'hFFFF_FFFF, 1'b0, 8'h02);      // flags ignored without TCP
		bkt = fta_pkg::BKT_W'($urandom_range(0, fta_pkg::BUCKETS - 1));
		for (int i = 0; i < fta_pkg::WAYS + 1; i++) begin
			crowd = flow_in_bucket(bkt);
			crowd.now_time = 32'd10;
			pending_beats.push_back(crowd);             // last one overflows
		end
		push_pkt(f0, 32'd100, 1'b1, 8'h06);            // match: SYN with RST
		push_sweep(32'd50);                            // nothing idle yet
		push_sweep(32'd0);                             // clock going backwards
		push_sweep(32'd311);                           // removes the crowded bucket
		push_sweep(32'hFFFF_FFFF);                     // clears all but the wrapped flow
		wait_drained();

		// Timeout zero: anything older than now goes on the next sweep
		write_timeout('0);
		build_pool();
		hold_req <= 1'b1;                              // fill up behind a stalled receiver
		for (int i = 0; i < 350; i++) push_random_beat();
		wait_drained();

		write_timeout(31'h7FFF_FFFF);
		build_pool();
		for (int i = 0; i < 350; i++) push_random_beat();
		wait_drained();

		write_timeout(31'($urandom_range(20, 400)));
		build_pool();
		for (int i = 0; i < 350; i++) push_random_beat();
		wait_drained();

		// Last part: full rate on both sides
		write_timeout(31'd60);
		quiet = 1'b1;
		build_pool();
		for (int i = 0; i < 350; i++) push_random_beat();
		wait_drained();
		repeat (20) @(posedge clk);

		if (err_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
